[hw/rtl/led_strip_frame_buffer_serializer_assert.svh]
// ----------------------------------------------------------------------------
// LED strip serializer assertion macros
// Concurrent assertion wrappers clocked on aclk; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_BUFFER_SERIALIZER_ASSERT_SVH
`define LED_STRIP_FRAME_BUFFER_SERIALIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define LSFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define LSFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LSFB_ASSERT(lbl, prop, msg)
`define LSFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/lsfb_pkg.sv]
// ----------------------------------------------------------------------------
// lsfb_pkg
// Shared types, codes and helpers of the LED strip frame buffer serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfb_pkg;

    localparam int unsigned LSFB_MAX_PIXELS = 32;

    localparam int unsigned CNT_W  = 6;   // pixel_count and pixel addresses
    localparam int unsigned IDX_W  = 8;   // pixel_index on the bus
    localparam int unsigned MASK_W = 3;
    localparam int unsigned CH_W   = 7;
    localparam int unsigned PIX_W  = 3 * CH_W;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WCNT_W = 2;
    localparam int unsigned FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd3;

    localparam logic [WCNT_W-1:0] WCNT_PIXEL = 2'd3;
    localparam logic [CNT_W:0]    LATCH_ROUND = 7'd31;

    // store request from the controller
    typedef struct packed {
        logic             rd_en;
        logic [CNT_W-1:0] rd_addr;
        logic             wr_en;
        logic [CNT_W-1:0] wr_addr;
        logic [PIX_W-1:0] wr_data;
        logic             clr_en;
        logic [CNT_W-1:0] clr_count;
    } st_req_t;

    typedef struct packed {
        logic [CH_W-1:0]   red_out;
        logic [CH_W-1:0]   green_out;
        logic [CH_W-1:0]   blue_out;
        logic              error;
        logic [BYTE_W-1:0] wire_byte_first;
        logic [BYTE_W-1:0] wire_byte_second;
        logic [BYTE_W-1:0] wire_byte_third;
        logic [WCNT_W-1:0] wire_count;
        logic              last;
    } res_t;

    // strip data byte: channel with the marker bit set
    function automatic logic [BYTE_W-1:0] wire_byte(input logic [CH_W-1:0] ch);
        return {1'b1, ch};
    endfunction

    // ceil(count / 32) latch bytes
    function automatic logic [WCNT_W-1:0] latch_bytes(input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + LATCH_ROUND;
        return sum[CNT_W:CNT_W-1];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lsfb_store.sv]
// ----------------------------------------------------------------------------
// lsfb_store
// Pixel memory, one 21-bit entry per pixel, registered read, with per-entry
// valid bits so that reset and clear read back as black.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfb_store
    import lsfb_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = LSFB_MAX_PIXELS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire st_req_t          req,
    output logic      [PIX_W-1:0] rd_pixel
);

    localparam int unsigned A_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [PIX_W-1:0]      mem [MAX_PIXELS];
    logic [PIX_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;
    logic [MAX_PIXELS-1:0] valid_reg;
    logic [MAX_PIXELS-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[A_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr[A_W-1:0]];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (req.clr_en) begin
            for (int i = 0; i < MAX_PIXELS; i++) begin
                if (CNT_W'(i) < req.clr_count) begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        if (req.wr_en) begin
            valid_next[req.wr_addr[A_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (req.rd_en) begin
                rd_vld_reg <= valid_reg[req.rd_addr[A_W-1:0]];
            end
        end
    end

    assign rd_pixel = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/lsfb_ctrl.sv]
// ----------------------------------------------------------------------------
// lsfb_ctrl
// Request sequencer: decodes a request, drives the pixel memory, does the
// masked read-modify-write and walks the store for an update. Holds the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_strip_frame_buffer_serializer_assert.svh"

module lsfb_ctrl
    import lsfb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [IDX_W-1:0]  pixel_index,
    input  wire logic [MASK_W-1:0] write_mask,
    input  wire logic [CH_W-1:0]   red,
    input  wire logic [CH_W-1:0]   green,
    input  wire logic [CH_W-1:0]   blue,
    input  wire logic [CNT_W-1:0]  eff_count,
    output st_req_t                st_req,
    input  wire logic [PIX_W-1:0]  rd_pixel,
    output logic                   m_valid,
    output res_t                   m_res,
    input  wire logic              m_ready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;
    localparam logic [1:0] ST_LATCH  = 2'd3;

    logic [1:0]        state_reg,   state_next;
    logic [FUNC_W-1:0] func_reg,    func_next;
    logic [CNT_W-1:0]  addr_reg,    addr_next;
    logic [MASK_W-1:0] mask_reg,    mask_next;
    logic [CH_W-1:0]   red_reg,     red_next;
    logic [CH_W-1:0]   green_reg,   green_next;
    logic [CH_W-1:0]   blue_reg,    blue_next;
    logic              err_reg,     err_next;
    logic [CNT_W-1:0]  ptr_reg,     ptr_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg,   m_res_next;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              in_err;
    logic              is_rw;
    logic [CH_W-1:0]   old_red, old_green, old_blue;
    res_t              res_v;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_rw    = (func == FUNC_WRITE) || (func == FUNC_READ);
    assign in_err   = (eff_count == '0) ||
                      (is_rw && (pixel_index >= {{(IDX_W-CNT_W){1'b0}}, eff_count}));

    assign old_red   = rd_pixel[3*CH_W-1:2*CH_W];
    assign old_green = rd_pixel[2*CH_W-1:CH_W];
    assign old_blue  = rd_pixel[CH_W-1:0];

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        addr_next    = addr_reg;
        mask_next    = mask_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        err_next     = err_reg;
        ptr_next     = ptr_reg;
        st_req       = '0;
        res_v        = '0;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next  = func;
                    addr_next  = pixel_index[CNT_W-1:0];
                    mask_next  = write_mask;
                    red_next   = red;
                    green_next = green;
                    blue_next  = blue;
                    err_next   = in_err;
                    ptr_next   = '0;
                    if (!in_err && is_rw) begin
                        st_req.rd_en   = 1'b1;
                        st_req.rd_addr = pixel_index[CNT_W-1:0];
                    end
                    if (!in_err && (func == FUNC_UPDATE)) begin
                        st_req.rd_en   = 1'b1;
                        st_req.rd_addr = '0;
                        state_next     = ST_STREAM;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    res_v.last = 1'b1;
                    if (err_reg) begin
                        res_v.error = 1'b1;
                    end else begin
                        case (func_reg)
                            FUNC_WRITE: begin
                                // merge over the current entry (black if never written)
                                st_req.wr_en   = 1'b1;
                                st_req.wr_addr = addr_reg;
                                st_req.wr_data = {mask_reg[2] ? red_reg   : old_red,
                                                  mask_reg[1] ? green_reg : old_green,
                                                  mask_reg[0] ? blue_reg  : old_blue};
                            end
                            FUNC_READ: begin
                                res_v.red_out   = old_red;
                                res_v.green_out = old_green;
                                res_v.blue_out  = old_blue;
                            end
                            FUNC_CLEAR: begin
                                st_req.clr_en    = 1'b1;
                                st_req.clr_count = eff_count;
                            end
                            default: begin
                            end
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_STREAM: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    res_v.wire_byte_first  = wire_byte(old_green);
                    res_v.wire_byte_second = wire_byte(old_red);
                    res_v.wire_byte_third  = wire_byte(old_blue);
                    res_v.wire_count       = WCNT_PIXEL;
                    if (({1'b0, ptr_reg} + 1'b1) < {1'b0, eff_count}) begin
                        st_req.rd_en   = 1'b1;
                        st_req.rd_addr = ptr_reg + 1'b1;
                        ptr_next       = ptr_reg + 1'b1;
                    end else begin
                        state_next = ST_LATCH;
                    end
                end
            end
            ST_LATCH: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    res_v.wire_count = latch_bytes(eff_count);
                    res_v.last       = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        m_res_next   = m_res_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_res_next   = res_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        addr_reg  <= addr_next;
        mask_reg  <= mask_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        err_reg   <= err_next;
        ptr_reg   <= ptr_next;
        m_res_reg <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    `LSFB_ASSERT(a_no_rd_wr_overlap, !(st_req.rd_en && st_req.wr_en), "store read and write together")
    `LSFB_ASSERT(a_accept_leaves_idle, (s_valid && s_ready) |=> (state_reg != ST_IDLE), "request accepted but sequencer idle")
    `LSFB_ASSERT(a_last_ends_request, (out_load && m_res_next.last) |=> (state_reg == ST_IDLE), "final result loaded but sequencer busy")
    `LSFB_ASSERT(a_error_is_last, m_valid_reg |-> (!m_res_reg.error || m_res_reg.last), "error result not marked last")

endmodule

`default_nettype wire

[hw/rtl/led_strip_frame_buffer_serializer.sv]
// ----------------------------------------------------------------------------
// led_strip_frame_buffer_serializer
// Frame buffer for a 7-bit RGB LED strip with per-pixel access, clear and
// serialized strip update.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_t*: s_tuser is the request kind (write, read, clear,
//   update), s_tdata the pixel index, write mask and channel values.
//   Results leave on m_t*: one per request, except update, which gives one
//   result per pixel in use (green, red, blue strip bytes) and then one with
//   the latch byte count; m_tlast marks the final result of a request and
//   m_tuser flags a refused request (bad index or pixel_count of zero).
//   pixel_count is loaded through cfg_wr_en / cfg_wr_data; the user must load
//   it only while idle, as the block does not enforce this. An accepted
//   request's memory read is registered; once the output register is free the
//   result is loaded into it (modify/write-back at the same time) and the next
//   request is taken after the return to idle. Update streams one pixel per
//   cycle from the registered read unless m_tready stalls, then the latch result.
//   Reset empties the store (all pixels black) and sets pixel_count to zero.
//   A stalled m_tready holds the result register and freezes a busy sequencer;
//   s_tready stays low until the current request has loaded its last result.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_frame_buffer_serializer
    import lsfb_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = LSFB_MAX_PIXELS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,  // pixel_count
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // pixel_index[7:0], write_mask[10:8], red[17:11], green[24:18], blue[31:25]
    input  wire logic [31:0]       s_tdata,
    input  wire logic [FUNC_W-1:0] s_tuser,      // func[1:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // red_out[6:0], green_out[13:7], blue_out[20:14], wire_byte_first[28:21],
    // wire_byte_second[36:29], wire_byte_third[44:37], wire_count[46:45], zero[47]
    output logic [47:0]            m_tdata,
    output logic                   m_tuser,      // error
    output logic                   m_tlast
);

    logic [CNT_W-1:0] pixel_count_reg;
    logic [CNT_W-1:0] eff_count;
    st_req_t          st_req;
    logic [PIX_W-1:0] rd_pixel;
    res_t             m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= '0;
        end else if (cfg_wr_en) begin
            pixel_count_reg <= cfg_wr_data;
        end
    end

    // counts above the store act as a full store
    assign eff_count = ({1'b0, pixel_count_reg} > (CNT_W+1)'(MAX_PIXELS)) ?
                       CNT_W'(MAX_PIXELS) : pixel_count_reg;

    lsfb_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (st_req),
        .rd_pixel (rd_pixel)
    );

    lsfb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .func        (s_tuser),
        .pixel_index (s_tdata[7:0]),
        .write_mask  (s_tdata[10:8]),
        .red         (s_tdata[17:11]),
        .green       (s_tdata[24:18]),
        .blue        (s_tdata[31:25]),
        .eff_count   (eff_count),
        .st_req      (st_req),
        .rd_pixel    (rd_pixel),
        .m_valid     (m_tvalid),
        .m_res       (m_res),
        .m_ready     (m_tready)
    );

    assign m_tdata = {1'b0,
                      m_res.wire_count,
                      m_res.wire_byte_third,
                      m_res.wire_byte_second,
                      m_res.wire_byte_first,
                      m_res.blue_out,
                      m_res.green_out,
                      m_res.red_out};
    assign m_tuser = m_res.error;
    assign m_tlast = m_res.last;

endmodule

`default_nettype wire
